// ===== design/halton_point_generator_assert.svh =====
// Assertion macros for the Halton point generator
`ifndef HALTON_POINT_GENERATOR_ASSERT_SVH
`define HALTON_POINT_GENERATOR_ASSERT_SVH

// same-cycle implication
`define HPG_AST_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HPG_AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/hpg_pkg.sv =====
// Shared types, widths and constant tables of the Halton point generator
package hpg_pkg;

    localparam int DEF_MAX_DIMS   = 32;
    localparam int DEF_INDEX_BITS = 31;
    localparam int PRIME_COUNT    = 54;

    localparam int DIV_W  = 42;
    localparam int DVD_W  = 68;
    localparam int STEP_W = 7;
    localparam int MA_W   = 42;
    localparam int MB_W   = 32;
    localparam int MP_W   = MA_W + MB_W;
    localparam int COEF_W = 40;

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

    localparam logic [7:0] PRIMES [PRIME_COUNT] = '{
        8'd2, 8'd3, 8'd5, 8'd7, 8'd11, 8'd13, 8'd17, 8'd19, 8'd23, 8'd29, 8'd31,
        8'd37, 8'd41, 8'd43, 8'd47, 8'd53, 8'd59, 8'd61, 8'd67, 8'd71, 8'd73,
        8'd79, 8'd83, 8'd89, 8'd97, 8'd101, 8'd103, 8'd107, 8'd109, 8'd113,
        8'd127, 8'd131, 8'd137, 8'd139, 8'd149, 8'd151, 8'd157, 8'd163, 8'd167,
        8'd173, 8'd179, 8'd181, 8'd191, 8'd193, 8'd197, 8'd199, 8'd211, 8'd223,
        8'd227, 8'd229, 8'd233, 8'd239, 8'd241, 8'd251
    };

    localparam coef_t POLY_P [5] = '{
        -40'sd86498610, -40'sd268435456, -40'sd91869911, -40'sd5482290, -40'sd12177
    };
    localparam coef_t POLY_Q [5] = '{
        40'sd26668650, 40'sd157996162, 40'sd142567000, 40'sd27793204, 40'sd1035106
    };

    localparam logic [27:0] Q28_HALF = 28'h8000000;
    localparam logic [27:0] EPS_Q    = 28'd268;
    localparam logic [27:0] U_HI     = 28'd268435188;
    localparam logic [28:0] Q28_ONE  = 29'h10000000;
    localparam logic [30:0] TWO_LN2  = 31'd1488522236;

endpackage

// ===== design/hpg_div.sv =====
// Shared restoring divider, one quotient bit per cycle
module hpg_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hpg_pkg::div_req_t        req,
    input  logic [hpg_pkg::DIV_W-1:0] rem_init,
    input  logic [hpg_pkg::DIV_W-1:0] divisor,
    input  logic [hpg_pkg::DVD_W-1:0] dvd_init,
    output hpg_pkg::div_rsp_t        rsp,
    output logic [hpg_pkg::DVD_W-1:0] quot,
    output logic [hpg_pkg::DIV_W-1:0] rem
);
    import hpg_pkg::*;

    logic [DIV_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  d_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_W-1:0]  rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg[DIV_W-2:0], dvd_reg[DVD_W-1]};
    assign ge     = rem_sh >= d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= rem_init;
            dvd_reg <= dvd_init;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sh - d_reg : rem_sh;
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign quot     = dvd_reg;
    assign rem      = rem_reg;
endmodule

// ===== design/hpg_mul.sv =====
// Shared unsigned multiplier with registered product
module hpg_mul (
    input  logic                     clk,
    input  logic [hpg_pkg::MA_W-1:0] a,
    input  logic [hpg_pkg::MB_W-1:0] b,
    output logic [hpg_pkg::MP_W-1:0] p
);
    import hpg_pkg::*;

    logic [MP_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= MP_W'(a) * MP_W'(b);
    end

    assign p = p_reg;
endmodule

// ===== design/halton_point_generator.sv =====
// Halton point generator top level: handshake, config, sequencer and datapath
//
// Usage:
//   Input channel (in_valid/in_stall, restart, end_of_batch): one word requests
//   one point. in_stall stays high from acceptance until the last coordinate
//   of that point has been taken.
//   Output channel (out_valid/out_stall): one word per coordinate, dims words
//   per point, in dimension order; last_of_point marks the final one and
//   batch_end echoes end_of_batch there.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 sets the
//   dimension count, index 1 the normal mode; cfg_ready is always high.
//   Per coordinate, uniform mode runs a digit loop on the shared divider, one
//   pass per digit of the point index in that prime base; normal mode adds
//   normalize, 28 squarings on the shared multiplier, a 32-step square root,
//   Horner, and a 68-step divide, and emits zero directly at exactly one half.
//   A held out_stall freezes the block with the coordinate in the output
//   register. Reset sets the point index to 1, dims to 1, uniform mode.
module halton_point_generator #(
    parameter int MAX_DIMS   = hpg_pkg::DEF_MAX_DIMS,
    parameter int INDEX_BITS = hpg_pkg::DEF_INDEX_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               restart,
    input  logic               end_of_batch,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [32:0] coord_value,
    output logic [4:0]         dim_index,
    output logic [30:0]        seq_index,
    output logic               last_of_point,
    output logic               batch_end,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [5:0]         cfg_data
);
    import hpg_pkg::*;

    `include "halton_point_generator_assert.svh"

    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam logic [0:0] CFG_DIMS   = 1'b0;
    localparam logic [0:0] CFG_NORMAL = 1'b1;

    typedef enum logic [17:0] {
        S_IDLE     = 18'h00001,
        S_DIG_INIT = 18'h00002,
        S_DIG_DIV  = 18'h00004,
        S_DIG_MR   = 18'h00008,
        S_DIG_MD   = 18'h00010,
        S_FRAC     = 18'h00020,
        S_N_PREP   = 18'h00040,
        S_N_NORM   = 18'h00080,
        S_SQ       = 18'h00100,
        S_SQ_W     = 18'h00200,
        S_L        = 18'h00400,
        S_L_W      = 18'h00800,
        S_SQRT     = 18'h01000,
        S_HA       = 18'h02000,
        S_HB       = 18'h04000,
        S_HC       = 18'h08000,
        S_QDIV     = 18'h10000,
        S_WAIT     = 18'h20000
    } state_t;

    state_t                state_reg, state_next;
    logic                  out_valid_reg;
    logic [INDEX_BITS-1:0] counter_reg;
    logic [5:0]            dims_reg;
    logic                  normal_reg;
    logic [DIM_W-1:0]      dim_reg;

    logic [INDEX_BITS-1:0] idx_reg, n_reg;
    logic [DIV_W-1:0]      r_reg, den_reg;
    logic [27:0]           u_reg, frac_reg;
    logic [31:0]           x_reg;
    logic [4:0]            sh_reg, sqi_reg;
    logic [63:0]           nsq_reg, res_reg, bit_reg;
    coef_t                 a_reg, b_reg;
    logic [1:0]            hi_reg;
    logic                  eob_reg;
    logic signed [32:0]    coord_reg;
    logic [4:0]            dimo_reg;
    logic [30:0]           seqo_reg;
    logic                  last_reg, bend_reg;

    div_req_t              div_req;
    div_rsp_t              div_rsp;
    logic [DIV_W-1:0]      div_rem_init, div_divisor, div_rem;
    logic [DVD_W-1:0]      div_dvd_init, div_quot;
    logic [MA_W-1:0]       mul_a;
    logic [MB_W-1:0]       mul_b;
    logic [MP_W-1:0]       mul_p;

    logic                  accept, emit, is_last;
    logic signed [32:0]    coord_next;
    logic [5:0]            dims_eff;
    logic [7:0]            prime;
    logic [27:0]           u_clamp, r_min;
    logic [31:0]           xs;
    logic [32:0]           l_val;
    logic [33:0]           y_val;
    logic [63:0]           sq_sum;
    logic [31:0]           t_val;
    coef_t                 a_abs, b_abs, m_q, ha_next, hb_next;
    logic signed [47:0]    qm48, qs48, rs48, cv48;

    hpg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .rem_init (div_rem_init),
        .divisor  (div_divisor),
        .dvd_init (div_dvd_init),
        .rsp      (div_rsp),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    hpg_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign prime    = PRIMES[dim_reg];
    assign dims_eff = (dims_reg == 6'd0) ? 6'd1 :
                      ((dims_reg > 6'(MAX_DIMS)) ? 6'(MAX_DIMS) : dims_reg);
    assign is_last  = (6'(dim_reg) == dims_eff - 6'd1);
    assign t_val    = res_reg[31:0];

    always_comb
    begin
        u_clamp = (u_reg > U_HI) ? U_HI : ((u_reg < EPS_Q) ? EPS_Q : u_reg);
        r_min   = (u_clamp > Q28_HALF) ? 28'(Q28_ONE - 29'(u_clamp)) : u_clamp;
        xs      = mul_p[61:30];
        l_val   = 33'((33'(sh_reg) - 33'd2) << 28) - 33'(frac_reg);
        y_val   = 34'((mul_p + (MP_W'(1) << 29)) >> 30);
        sq_sum  = res_reg + bit_reg;
        a_abs   = a_reg[COEF_W-1] ? -a_reg : a_reg;
        b_abs   = b_reg[COEF_W-1] ? -b_reg : b_reg;
        m_q     = coef_t'(mul_p[COEF_W+27:28]);
        ha_next = (a_reg[COEF_W-1] ? -m_q : m_q) + POLY_P[hi_reg];
        hb_next = (b_reg[COEF_W-1] ? -m_q : m_q) + POLY_Q[hi_reg];
        qm48    = signed'(div_quot[47:0]);
        qs48    = a_reg[COEF_W-1] ? -qm48 : qm48;
        rs48    = signed'(48'(t_val)) + qs48;
        cv48    = (u_reg < Q28_HALF) ? -rs48 : rs48;
    end

    // shared unit operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        div_req.start = 1'b0;
        div_req.steps = '0;
        div_rem_init  = '0;
        div_divisor   = '0;
        div_dvd_init  = '0;
        unique case (state_reg)
            S_DIG_DIV:
            begin
                mul_a = r_reg;
                mul_b = MB_W'(prime);
            end
            S_DIG_MR:
            begin
                mul_a = den_reg;
                mul_b = MB_W'(prime);
            end
            S_SQ:
            begin
                mul_a = MA_W'(x_reg);
                mul_b = x_reg;
            end
            S_L:
            begin
                mul_a = MA_W'(l_val);
                mul_b = MB_W'(TWO_LN2);
            end
            S_HA:
            begin
                mul_a = MA_W'($unsigned(a_abs));
                mul_b = t_val;
            end
            S_HB:
            begin
                mul_a = MA_W'($unsigned(b_abs));
                mul_b = t_val;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        unique case (state_reg)
            S_DIG_INIT:
            begin
                div_req.start = 1'b1;
                if (idx_reg != '0)
                begin
                    div_req.steps = STEP_W'(INDEX_BITS);
                    div_dvd_init  = DVD_W'({idx_reg, (DVD_W-INDEX_BITS)'(0)});
                    div_divisor   = DIV_W'(prime);
                end
                else
                begin
                    div_req.steps = STEP_W'(28);
                    div_divisor   = DIV_W'(1);
                end
            end
            S_DIG_MD:
            begin
                div_req.start = 1'b1;
                if (n_reg != '0)
                begin
                    div_req.steps = STEP_W'(INDEX_BITS);
                    div_dvd_init  = DVD_W'({n_reg, (DVD_W-INDEX_BITS)'(0)});
                    div_divisor   = DIV_W'(prime);
                end
                else
                begin
                    div_req.steps = STEP_W'(28);
                    div_rem_init  = r_reg;
                    div_divisor   = mul_p[DIV_W-1:0];
                end
            end
            S_HC:
            begin
                if (hi_reg == 2'd0)
                begin
                    div_req.start = 1'b1;
                    div_req.steps = STEP_W'(DVD_W);
                    div_dvd_init  = DVD_W'({$unsigned(a_abs), 28'd0});
                    div_divisor   = DIV_W'($unsigned(hb_next));
                end
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        emit       = 1'b0;
        coord_next = '0;
        unique case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_DIG_INIT;
            S_DIG_INIT: state_next = (idx_reg != '0) ? S_DIG_DIV : S_FRAC;
            S_DIG_DIV:  if (div_rsp.done) state_next = S_DIG_MR;
            S_DIG_MR:   state_next = S_DIG_MD;
            S_DIG_MD:   state_next = (n_reg != '0) ? S_DIG_DIV : S_FRAC;
            S_FRAC:
            begin
                if (div_rsp.done)
                begin
                    if (normal_reg)
                    begin
                        state_next = S_N_PREP;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        coord_next = 33'(div_quot[27:0]);
                        state_next = S_WAIT;
                    end
                end
            end
            S_N_PREP:
            begin
                if (u_clamp == Q28_HALF)
                begin
                    emit       = 1'b1;
                    state_next = S_WAIT;
                end
                else
                begin
                    state_next = S_N_NORM;
                end
            end
            S_N_NORM:   if (x_reg[30]) state_next = S_SQ;
            S_SQ:       state_next = S_SQ_W;
            S_SQ_W:     state_next = (sqi_reg == 5'd27) ? S_L : S_SQ;
            S_L:        state_next = S_L_W;
            S_L_W:      state_next = S_SQRT;
            S_SQRT:     if (bit_reg[0]) state_next = S_HA;
            S_HA:       state_next = S_HB;
            S_HB:       state_next = S_HC;
            S_HC:       state_next = (hi_reg == 2'd0) ? S_QDIV : S_HA;
            S_QDIV:
            begin
                if (div_rsp.done)
                begin
                    emit       = 1'b1;
                    coord_next = cv48[32:0];
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!out_stall)
                begin
                    state_next = last_reg ? S_IDLE : S_DIG_INIT;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            counter_reg   <= INDEX_BITS'(1);
            dims_reg      <= 6'd1;
            normal_reg    <= 1'b0;
            dim_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_DIMS:   dims_reg   <= cfg_data;
                    CFG_NORMAL: normal_reg <= cfg_data[0];
                endcase
            end
            if (accept)
            begin
                dim_reg <= '0;
                if (restart)
                begin
                    counter_reg <= INDEX_BITS'(1);
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
                if (last_reg)
                begin
                    counter_reg <= idx_reg + INDEX_BITS'(1);
                end
                else
                begin
                    dim_reg <= dim_reg + DIM_W'(1);
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= restart ? INDEX_BITS'(1) : counter_reg;
            eob_reg <= end_of_batch;
        end
        if (emit)
        begin
            coord_reg <= coord_next;
            dimo_reg  <= 5'(dim_reg);
            seqo_reg  <= 31'(idx_reg);
            last_reg  <= is_last;
            bend_reg  <= is_last && eob_reg;
        end
        unique case (state_reg)
            S_DIG_INIT:
            begin
                r_reg   <= '0;
                den_reg <= DIV_W'(1);
            end
            S_DIG_DIV:  if (div_rsp.done) n_reg <= div_quot[INDEX_BITS-1:0];
            S_DIG_MR:   r_reg <= mul_p[DIV_W-1:0] + div_rem;
            S_DIG_MD:   den_reg <= mul_p[DIV_W-1:0];
            S_FRAC:     if (div_rsp.done) u_reg <= div_quot[27:0];
            S_N_PREP:
            begin
                u_reg  <= u_clamp;
                x_reg  <= 32'(r_min);
                sh_reg <= '0;
            end
            S_N_NORM:
            begin
                frac_reg <= '0;
                sqi_reg  <= '0;
                if (!x_reg[30])
                begin
                    x_reg  <= {x_reg[30:0], 1'b0};
                    sh_reg <= sh_reg + 5'd1;
                end
            end
            S_SQ_W:
            begin
                if (xs[31])
                begin
                    x_reg <= {1'b0, xs[31:1]};
                    frac_reg[5'd27 - sqi_reg] <= 1'b1;
                end
                else
                begin
                    x_reg <= xs;
                end
                sqi_reg <= sqi_reg + 5'd1;
            end
            S_L_W:
            begin
                nsq_reg <= 64'({y_val, 28'd0});
                res_reg <= '0;
                bit_reg <= 64'(1) << 62;
            end
            S_SQRT:
            begin
                if (nsq_reg >= sq_sum)
                begin
                    nsq_reg <= nsq_reg - sq_sum;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                a_reg   <= POLY_P[4];
                b_reg   <= POLY_Q[4];
                hi_reg  <= 2'd3;
            end
            S_HB:       a_reg <= ha_next;
            S_HC:
            begin
                b_reg  <= hb_next;
                hi_reg <= hi_reg - 2'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign coord_value   = coord_reg;
    assign dim_index     = dimo_reg;
    assign seq_index     = seqo_reg;
    assign last_of_point = last_reg;
    assign batch_end     = bend_reg;
    assign cfg_ready     = 1'b1;

    `HPG_AST_IMP(a_idle_no_word, !in_stall, !out_valid, "word pending while idle")
    `HPG_AST_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "not busy after accept")
    `HPG_AST_IMP(a_uniform_range, out_valid && !normal_reg, coord_value[32:28] == 5'd0,
        "uniform coordinate out of range")
    `HPG_AST_IMP(a_bend_last, out_valid && !last_of_point, !batch_end,
        "batch_end off the last coordinate")
    `HPG_AST_IMP(a_div_free, div_req.start, !div_rsp.busy, "divider started while busy")
endmodule

// ===== dv/halton_point_generator_tb.sv =====
// Self-checking testbench for the Halton point generator: directed table, random phases
module halton_point_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIMS    = hpg_pkg::DEF_MAX_DIMS;
    localparam int IDLE_LIMIT  = 40000;
    localparam int HOLD_CYCLES = 3000;
    localparam logic [0:0] REG_DIMS   = 1'b0;
    localparam logic [0:0] REG_NORMAL = 1'b1;

    typedef struct {
        logic signed [32:0] coord;
        logic [4:0]         dim;
        logic [30:0]        seq;
        logic               last;
        logic               bend;
    } coord_word_t;

    typedef struct {
        int          dims;
        bit          normal;
        bit          restart;
        bit          eob;
        bit          has_exp;
        longint      exp0;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               restart = 1'b0;
    logic               end_of_batch = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [32:0] coord_value;
    logic [4:0]         dim_index;
    logic [30:0]        seq_index;
    logic               last_of_point;
    logic               batch_end;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [0:0]         cfg_index = 1'b0;
    logic [5:0]         cfg_data = 6'd0;

    coord_word_t        coord_q[$];
    longint unsigned    point_idx = 1;
    int                 dims_reg = 1;
    bit                 normal_reg = 1'b0;
    int                 errors = 0;
    int                 sent = 0;
    int                 idle_cnt = 0;
    bit                 calm = 1'b0;
    bit                 hold = 1'b0;

    halton_point_generator dut (.*);

    always #2 clk = ~clk;

    function automatic longint unsigned radical_q28(longint unsigned idx, longint unsigned b);
        longint unsigned r, den, q;
        r = 0; den = 1; q = 0;
        while (idx != 0) begin
            r = r * b + idx % b;
            den = den * b;
            idx = idx / b;
        end
        for (int i = 0; i < 28; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > n) bt = bt >> 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n = n - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic longint mul_q28(longint a, longint b);
        longint unsigned ma, mb, m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m = (ma * mb) >> 28;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint inv_normal(longint unsigned u);
        longint unsigned r, x, frac, ll, y, t, mag, qm;
        longint a, b, q, res;
        int k;
        frac = 0;
        k = 0;
        if (u > hpg_pkg::U_HI) u = hpg_pkg::U_HI;
        if (u < hpg_pkg::EPS_Q) u = hpg_pkg::EPS_Q;
        if (u == hpg_pkg::Q28_HALF) return 0;
        r = (u > hpg_pkg::Q28_HALF) ? hpg_pkg::Q28_ONE - u : u;
        while ((r >> (k + 1)) != 0) k++;
        x = r << (30 - k);
        for (int i = 1; i <= 28; i++) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                frac = frac | (64'd1 << (28 - i));
            end
        end
        ll = (longint'(28 - k) << 28) - frac;
        y = (ll * hpg_pkg::TWO_LN2 + (64'd1 << 29)) >> 30;
        t = isqrt(y << 28);
        a = hpg_pkg::POLY_P[4];
        b = hpg_pkg::POLY_Q[4];
        for (int i = 3; i >= 0; i--) begin
            a = mul_q28(a, t) + hpg_pkg::POLY_P[i];
            b = mul_q28(b, t) + hpg_pkg::POLY_Q[i];
        end
        mag = (a < 0) ? -a : a;
        qm = (mag << 28) / b;
        q = (a < 0) ? -longint'(qm) : longint'(qm);
        res = longint'(t) + q;
        return (u < hpg_pkg::Q28_HALF) ? -res : res;
    endfunction

    // queues the expected words of one point and returns its first coordinate
    function automatic longint predict_point(bit rs, bit eob);
        int          n;
        longint      v, first;
        coord_word_t w;
        n = (dims_reg == 0) ? 1 : (dims_reg > MAX_DIMS ? MAX_DIMS : dims_reg);
        if (rs) point_idx = 1;
        first = 0;
        for (int j = 0; j < n; j++) begin
            v = radical_q28(point_idx, hpg_pkg::PRIMES[j]);
            if (normal_reg) v = inv_normal(v);
            if (j == 0) first = v;
            w.coord = v[32:0];
            w.dim   = j[4:0];
            w.seq   = point_idx[30:0];
            w.last  = (j == n - 1);
            w.bend  = (j == n - 1) ? eob : 1'b0;
            coord_q.push_back(w);
        end
        point_idx = (point_idx + 1) & 64'h7FFF_FFFF;
        return first;
    endfunction

    task automatic cfg_write(logic [0:0] idx, logic [5:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_DIMS) dims_reg = data;
        else normal_reg = data[0];
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int d, bit nm);
        wait (coord_q.size() == 0);
        repeat (8) @(posedge clk);
        cfg_write(REG_DIMS, d[5:0]);
        cfg_write(REG_NORMAL, {5'($urandom_range(31)), nm});
    endtask

    task automatic send_point(bit rs, bit eob, output longint first);
        @(posedge clk);
        while (!calm && $urandom_range(99) < 25) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        restart      <= rs;
        end_of_batch <= eob;
        do @(posedge clk); while (in_stall);
        first = predict_point(rs, eob);
        sent++;
        in_valid <= 1'b0;
    endtask

    stim_row_t table_rows[] = '{
        '{1,  0, 1, 0, 1, 134217728},
        '{1,  0, 0, 1, 1, 67108864},
        '{1,  0, 0, 0, 1, 201326592},
        '{0,  0, 1, 1, 1, 134217728},
        '{0,  0, 0, 0, 0, 0},
        '{63, 0, 0, 1, 0, 0},
        '{32, 0, 1, 1, 1, 134217728},
        '{32, 0, 0, 0, 0, 0},
        '{3,  1, 1, 0, 1, 0},
        '{3,  1, 0, 1, 0, 0},
        '{3,  1, 0, 0, 0, 0},
        '{32, 1, 0, 1, 0, 0},
        '{2,  1, 1, 1, 1, 0},
        '{5,  0, 0, 1, 0, 0},
        '{4,  1, 0, 0, 0, 0}
    };

    always @(posedge clk) begin
        if (hold) out_stall <= 1'b1;
        else out_stall <= !calm && ($urandom_range(99) < 25);
    end

    initial begin
        wait (sent == 100);
        hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold = 1'b0;
    end

    always @(posedge clk) begin
        coord_word_t e;
        if (out_valid && !out_stall) begin
            if (coord_q.size() == 0) begin
                $error("unexpected word: coord_value %0d", coord_value);
                errors++;
            end else begin
                e = coord_q.pop_front();
                if (coord_value !== e.coord) begin
                    $error("coord_value exp %0d got %0d", e.coord, coord_value);
                    errors++;
                end
                if (dim_index !== e.dim) begin
                    $error("dim_index exp %0d got %0d", e.dim, dim_index);
                    errors++;
                end
                if (seq_index !== e.seq) begin
                    $error("seq_index exp %0d got %0d", e.seq, seq_index);
                    errors++;
                end
                if (last_of_point !== e.last) begin
                    $error("last_of_point exp %0b got %0b", e.last, last_of_point);
                    errors++;
                end
                if (batch_end !== e.bend) begin
                    $error("batch_end exp %0b got %0b", e.bend, batch_end);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > IDLE_LIMIT) begin
            $display("halton_point_generator_tb NOT OK");
            $finish;
        end
    end

    initial begin
        longint first;
        int     plen, d;
        bit     nm;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < table_rows.size(); i++) begin
            if (i == 0 || table_rows[i].dims != dims_reg || table_rows[i].normal != normal_reg)
                set_config(table_rows[i].dims, table_rows[i].normal);
            send_point(table_rows[i].restart, table_rows[i].eob, first);
            if (table_rows[i].has_exp && first != table_rows[i].exp0) begin
                $error("coord_value table exp %0d predicted %0d", table_rows[i].exp0, first);
                errors++;
            end
        end
        while (sent < 270) begin
            if ($urandom_range(9) == 0) begin
                d = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 32 : 63);
                plen = 2;
            end else begin
                d = $urandom_range(1, 5);
                plen = $urandom_range(10, 40);
            end
            nm = $urandom_range(1);
            set_config(d, nm);
            calm = (sent > 150 && sent < 200);
            for (int k = 0; k < plen && sent < 270; k++) begin
                if (sent == 230) wait (coord_q.size() == 0);
                send_point($urandom_range(15) == 0, $urandom_range(3) == 0, first);
            end
            calm = 1'b0;
        end
        wait (coord_q.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("halton_point_generator_tb OK");
        else
            $display("halton_point_generator_tb NOT OK");
        $finish;
    end
endmodule
